// ----- hdl/pbh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbh_pkg;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned AXIS_W  = 8;
  localparam int unsigned LIN_W   = 24;
  localparam int unsigned STORE_DEPTH = 4096;

  // stream widths, whole bytes
  localparam int unsigned S_TDATA_W = 176;
  localparam int unsigned M_TDATA_W = 48;

  // grid defaults
  localparam int unsigned BOXES_X_DEF = 16;
  localparam int unsigned BOXES_Y_DEF = 16;
  localparam int unsigned BOXES_Z_DEF = 16;

  // special values
  localparam logic [DATA_W-1:0] SKIP_Z    = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z   = 3'd5;

  // request kinds
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/pbh_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/particle_box_histogram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// a request walks through the subtract, multiply, index, memory read and write-back steps in turn
//   before its result reaches the output register; a new request is accepted only once the
//   last one has left the write-back step, which waits while the output register is still full
// the output register lets the next request in while a result still waits downstream
// reset: asynchronous, active low; afterwards a clearing pass zeroes all 4096 counters,
//   during which no request is accepted (configuration writes are)

module particle_box_histogram #(
  parameter int unsigned BOXES_X = pbh_pkg::BOXES_X_DEF,
  parameter int unsigned BOXES_Y = pbh_pkg::BOXES_Y_DEF,
  parameter int unsigned BOXES_Z = pbh_pkg::BOXES_Z_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, pos_z, release_time, now_time, box_address, zero fill
  input  wire logic [pbh_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // mode
  input  wire logic [0:0]                       s_axis_tuser,
  // last_particle
  input  wire logic                             s_axis_tlast,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // box_index, count_value, zero fill
  output logic      [pbh_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // counted
  output logic      [0:0]                       m_axis_tuser,
  // pass_done
  output logic                                  m_axis_tlast,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pbh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pbh_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DW = pbh_pkg::DATA_W;
  localparam int unsigned AW = pbh_pkg::ADDR_W;
  localparam int unsigned CW = pbh_pkg::CNT_W;
  localparam int unsigned LW = pbh_pkg::LIN_W;
  localparam int unsigned XW = pbh_pkg::AXIS_W;

  // linear index strides
  localparam logic [LW-1:0] PLANE = LW'(BOXES_Y * BOXES_X);
  localparam logic [LW-1:0] ROW   = LW'(BOXES_X);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_IDX  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RMW  = 3'd5;

  logic [2:0] state_q, state_d;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] lower_x_q, lower_y_q, lower_z_q;
  logic [DW-1:0] inv_x_q, inv_y_q, inv_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_x_q <= '0;
      lower_y_q <= '0;
      lower_z_q <= '0;
      inv_x_q   <= pbh_pkg::ONE_Q16;
      inv_y_q   <= pbh_pkg::ONE_Q16;
      inv_z_q   <= pbh_pkg::ONE_Q16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pbh_pkg::CFG_LOWER_X: lower_x_q <= cfg_data_i;
        pbh_pkg::CFG_LOWER_Y: lower_y_q <= cfg_data_i;
        pbh_pkg::CFG_LOWER_Z: lower_z_q <= cfg_data_i;
        pbh_pkg::CFG_INV_X:   inv_x_q   <= cfg_data_i;
        pbh_pkg::CFG_INV_Y:   inv_y_q   <= cfg_data_i;
        pbh_pkg::CFG_INV_Z:   inv_z_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // clearing pass after reset
  // ---------------------------------------------------------------------------
  logic [AW:0] clr_cnt_q;
  logic        clr_busy;

  assign clr_busy = !clr_cnt_q[AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // request capture
  // ---------------------------------------------------------------------------
  logic s_accept;
  assign s_axis_tready = (state_q == S_IDLE) && !clr_busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  logic          read_q, last_q;
  logic [DW-1:0] pos_x_q, pos_y_q, pos_z_q, rel_q, now_q;
  logic [AW-1:0] baddr_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      read_q  <= (s_axis_tuser[0] == pbh_pkg::MODE_READ);
      last_q  <= s_axis_tlast;
      pos_x_q <= s_axis_tdata[0 +: DW];
      pos_y_q <= s_axis_tdata[DW +: DW];
      pos_z_q <= s_axis_tdata[2*DW +: DW];
      rel_q   <= s_axis_tdata[3*DW +: DW];
      now_q   <= s_axis_tdata[4*DW +: DW];
      baddr_q <= s_axis_tdata[5*DW +: AW];
    end
  end

  // ---------------------------------------------------------------------------
  // offsets from the lower bounds, early rejects
  // ---------------------------------------------------------------------------
  logic [DW:0]   dx, dy, dz;
  logic          early_miss;
  logic [DW-1:0] diff_x_q, diff_y_q, diff_z_q;
  logic          miss_q;

  assign dx = {pos_x_q[DW-1], pos_x_q} - {lower_x_q[DW-1], lower_x_q};
  assign dy = {pos_y_q[DW-1], pos_y_q} - {lower_y_q[DW-1], lower_y_q};
  assign dz = {pos_z_q[DW-1], pos_z_q} - {lower_z_q[DW-1], lower_z_q};

  // sign of the 33-bit difference flags a coordinate below its bound
  assign early_miss = ($signed(rel_q) > $signed(now_q)) ||
                      (pos_z_q == pbh_pkg::SKIP_Z) ||
                      dx[DW] || dy[DW] || dz[DW];

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIFF) begin
      diff_x_q <= dx[DW-1:0];
      diff_y_q <= dy[DW-1:0];
      diff_z_q <= dz[DW-1:0];
      miss_q   <= early_miss;
    end
  end

  // ---------------------------------------------------------------------------
  // scale by the reciprocal box sizes, one 32x32 multiplier per axis
  // ---------------------------------------------------------------------------
  logic [2*DW-1:0] prod_x_q, prod_y_q, prod_z_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_x_q <= 64'(diff_x_q) * 64'(inv_x_q);
      prod_y_q <= 64'(diff_y_q) * 64'(inv_y_q);
      prod_z_q <= 64'(diff_z_q) * 64'(inv_z_q);
    end
  end

  // ---------------------------------------------------------------------------
  // axis indices and linear box address
  // ---------------------------------------------------------------------------
  logic [DW-1:0] whole_x, whole_y, whole_z;
  logic          in_grid;
  logic [LW-1:0] lin;
  logic [AW-1:0] addr_q;
  logic          hit_q;

  assign whole_x = prod_x_q[2*DW-1:DW];
  assign whole_y = prod_y_q[2*DW-1:DW];
  assign whole_z = prod_z_q[2*DW-1:DW];

  assign in_grid = (whole_x < DW'(BOXES_X)) &&
                   (whole_y < DW'(BOXES_Y)) &&
                   (whole_z < DW'(BOXES_Z));

  assign lin = LW'(whole_z[XW-1:0]) * PLANE +
               LW'(whole_y[XW-1:0]) * ROW +
               LW'(whole_x[XW-1:0]);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDX) begin
      hit_q  <= !read_q && !miss_q && in_grid && (lin < LW'(pbh_pkg::STORE_DEPTH));
      addr_q <= read_q ? baddr_q : lin[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // counter store, read-modify-write
  // ---------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [CW-1:0] ram_rdata;
  logic [CW-1:0] count_new;
  logic          out_load;

  // a counter at its maximum stays there
  assign count_new = (ram_rdata == pbh_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
  assign out_load  = (state_q == S_RMW) && (!m_axis_tvalid || m_axis_tready);

  // clearing pass owns the write port until it is through
  assign ram_we    = clr_busy || (out_load && hit_q);
  assign ram_waddr = clr_busy ? clr_cnt_q[AW-1:0] : addr_q;
  assign ram_wdata = clr_busy ? '0 : count_new;

  pbh_ram #(
    .WIDTH (CW),
    .DEPTH (pbh_pkg::STORE_DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_accept) state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_IDX;
      S_IDX:  state_d = S_RD;
      S_RD:   state_d = S_RMW;
      S_RMW:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic          m_valid_q;
  logic          counted_q, pass_q;
  logic [AW-1:0] box_idx_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      counted_q <= hit_q;
      pass_q    <= last_q;
      box_idx_q <= (read_q || hit_q) ? addr_q : '0;
      count_q   <= read_q ? ram_rdata : (hit_q ? count_new : '0);
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {{(pbh_pkg::M_TDATA_W - AW - CW){1'b0}}, count_q, box_idx_q};
  assign m_axis_tuser[0] = counted_q;
  assign m_axis_tlast    = pass_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_result_from_rmw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_RMW))
    else $error("result appeared without a write-back step");

  a_write_only_on_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !clr_busy) |-> (state_q == S_RMW && hit_q && !read_q))
    else $error("counter store written outside a counted hit");

  a_counted_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && counted_q) |-> (count_q != '0))
    else $error("counted hit reports a zero count");

  a_idle_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (state_q == S_IDLE && !m_valid_q))
    else $error("request in flight during the clearing pass");

endmodule

`default_nettype wire

// ----- test/pbh_count_checker.sv -----
`timescale 1ns / 1ps

module pbh_count_checker
  import pbh_pkg::*;
#(
  parameter int unsigned BOXES_X = BOXES_X_DEF,
  parameter int unsigned BOXES_Y = BOXES_Y_DEF,
  parameter int unsigned BOXES_Z = BOXES_Z_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]            s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic [0:0]            m_axis_tuser,
  input  wire logic                  m_axis_tlast,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [DATA_W-1:0]     cfg_data_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic              counted;
    logic [ADDR_W-1:0] box_index;
    logic [CNT_W-1:0]  count_value;
    logic              pass_done;
  } bin_result_t;

  logic [CNT_W-1:0]  box_counts [STORE_DEPTH];
  logic [DATA_W-1:0] grid_lower [3];
  logic [DATA_W-1:0] grid_inv   [3];
  bin_result_t       expected_bins [$];
  bin_result_t       seen, wanted;
  int                mismatches;

  assign errors_o = mismatches;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch in %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // per-axis slot, 0 when the coordinate lies outside the grid on that axis
  function automatic bit axis_slot(input logic [DATA_W-1:0] pos, bound, inv,
                                   input int unsigned boxes,
                                   output logic [AXIS_W-1:0] idx);
    logic [DATA_W:0] diff;
    logic [63:0]     prod;
    idx  = '0;
    diff = {pos[DATA_W-1], pos} - {bound[DATA_W-1], bound};
    if (diff[DATA_W]) return 1'b0;
    prod = {32'd0, diff[DATA_W-1:0]} * {32'd0, inv};
    if (prod[63:32] >= boxes) return 1'b0;
    idx = prod[32 +: AXIS_W];
    return 1'b1;
  endfunction

  // bins one request and, for a counted accumulate request, updates the histogram copy
  function automatic bin_result_t bin_particle(input logic mode,
                                               input logic [DATA_W-1:0] px, py, pz,
                                               input logic [DATA_W-1:0] rel_t, now_t,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic last);
    bin_result_t       r;
    logic [AXIS_W-1:0] ix, iy, iz;
    int unsigned       lin;
    r = '{counted: 1'b0, box_index: '0, count_value: '0, pass_done: last};
    if (mode == MODE_READ) begin
      r.box_index   = addr;
      r.count_value = box_counts[addr];
      return r;
    end
    if ($signed(rel_t) > $signed(now_t)) return r;
    if (pz == SKIP_Z) return r;
    if (!axis_slot(px, grid_lower[0], grid_inv[0], BOXES_X, ix)) return r;
    if (!axis_slot(py, grid_lower[1], grid_inv[1], BOXES_Y, iy)) return r;
    if (!axis_slot(pz, grid_lower[2], grid_inv[2], BOXES_Z, iz)) return r;
    lin = iz * BOXES_Y * BOXES_X + iy * BOXES_X + ix;
    if (lin >= STORE_DEPTH) return r;
    if (box_counts[lin] != COUNT_MAX) box_counts[lin] = box_counts[lin] + 1'b1;
    r.counted     = 1'b1;
    r.box_index   = lin[ADDR_W-1:0];
    r.count_value = box_counts[lin];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) box_counts[i] = '0;
      for (int a = 0; a < 3; a++) begin
        grid_lower[a] = '0;
        grid_inv[a]   = ONE_Q16;
      end
      expected_bins.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LOWER_X: grid_lower[0] = cfg_data_i;
          CFG_LOWER_Y: grid_lower[1] = cfg_data_i;
          CFG_LOWER_Z: grid_lower[2] = cfg_data_i;
          CFG_INV_X:   grid_inv[0]   = cfg_data_i;
          CFG_INV_Y:   grid_inv[1]   = cfg_data_i;
          CFG_INV_Z:   grid_inv[2]   = cfg_data_i;
          default:     ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_bins.push_back(bin_particle(s_axis_tuser[0],
                                             s_axis_tdata[31:0], s_axis_tdata[63:32],
                                             s_axis_tdata[95:64], s_axis_tdata[127:96],
                                             s_axis_tdata[159:128], s_axis_tdata[171:160],
                                             s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{counted: m_axis_tuser[0], box_index: m_axis_tdata[11:0],
                 count_value: m_axis_tdata[43:12], pass_done: m_axis_tlast};
        if (expected_bins.size() == 0) begin
          report("result with nothing outstanding", seen, '0);
        end else begin
          wanted = expected_bins.pop_front();
          if (seen.counted != wanted.counted)
            report("counted", seen.counted, wanted.counted);
          if (seen.box_index != wanted.box_index)
            report("box_index", seen.box_index, wanted.box_index);
          if (seen.count_value != wanted.count_value)
            report("count_value", seen.count_value, wanted.count_value);
          if (seen.pass_done != wanted.pass_done)
            report("pass_done", seen.pass_done, wanted.pass_done);
        end
      end
      pending_o <= expected_bins.size();
    end
  end

endmodule

// ----- test/tb_particle_box_histogram.sv -----
`timescale 1ns / 1ps

module tb_particle_box_histogram;
  import pbh_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 188;
  // indexes past the register map, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [DATA_W-1:0] MINUS_EIGHT = 32'hFFF8_0000;
  localparam logic [DATA_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] POS_MIN     = 32'h8000_0000;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  int                   errors, pending;
  int unsigned          cycle_cnt  = 0;
  int unsigned          stall_left = 0;
  bit                   gaps_on    = 1'b1;
  logic [DATA_W-1:0]    cur_lower [3];
  logic [DATA_W-1:0]    cur_inv   [3];
  logic [ADDR_W-1:0]    recent_boxes [$];

  particle_box_histogram dut (.*);

  pbh_count_checker u_checker (.*, .errors_o(errors), .pending_o(pending));

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_len(input int unsigned none_pct);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < none_pct) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // result side back-pressure, off in the quiet phases
  always @(posedge clk_i) begin
    if (!gaps_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(99) < 15) begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_len(0) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // valid stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_grid(input logic [DATA_W-1:0] lx, ly, lz, vx, vy, vz,
                           input bit spare);
    write_reg(CFG_LOWER_X, lx);
    write_reg(CFG_LOWER_Y, ly);
    write_reg(CFG_LOWER_Z, lz);
    write_reg(CFG_INV_X, vx);
    write_reg(CFG_INV_Y, vy);
    write_reg(CFG_INV_Z, vz);
    if (spare) write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
    cfg_valid_i <= 1'b0;
    cur_lower = '{lx, ly, lz};
    cur_inv   = '{vx, vy, vz};
  endtask

  // one request, then an optional gap; valid is only dropped when a gap follows
  task automatic send(input logic mode, input logic [DATA_W-1:0] px, py, pz, rel_t, now_t,
                      input logic [ADDR_W-1:0] addr, input logic last);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, addr, now_t, rel_t, pz, py, px};
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = gaps_on ? idle_len(45) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // the request line drops first so the last request is not taken again
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // position on one axis, mostly aimed at a chosen slot of the grid
  function automatic logic [DATA_W-1:0] pick_pos(input logic [DATA_W-1:0] bound, inv,
                                                 input int unsigned boxes,
                                                 output int slot);
    int unsigned sel;
    logic [63:0] span;
    sel  = $urandom_range(99);
    slot = -1;
    if (sel < 72) begin
      if (inv == '0) begin
        slot = 0;
        return bound + 32'($urandom_range(0, 1 << 20));
      end
      slot = $urandom_range(boxes - 1);
      span = {32'(slot), 32'($urandom())} / {32'd0, inv};
      if (span[63:32] != 0) span = 64'hFFFF_FFFF;
      return bound + span[31:0];
    end
    if (sel < 77) begin
      // right at the far edge of the grid
      span = (inv == '0) ? 64'hFFFF_FFFF : {32'(boxes), 32'd0} / {32'd0, inv};
      if (span[63:32] != 0) span = 64'hFFFF_FFFF;
      return bound + span[31:0];
    end
    if (sel < 84) return bound;
    if (sel < 88) return bound - 1'b1;
    if (sel < 92) return $urandom_range(1) ? POS_MAX : POS_MIN;
    return $urandom();
  endfunction

  task automatic random_request();
    int                sx, sy, sz;
    int unsigned       sel;
    logic              mode;
    logic [DATA_W-1:0] px, py, pz, rel_t, now_t;
    logic [ADDR_W-1:0] addr;
    mode = ($urandom_range(99) < 20) ? MODE_READ : MODE_ACCUM;
    px   = pick_pos(cur_lower[0], cur_inv[0], BOXES_X_DEF, sx);
    py   = pick_pos(cur_lower[1], cur_inv[1], BOXES_Y_DEF, sy);
    pz   = pick_pos(cur_lower[2], cur_inv[2], BOXES_Z_DEF, sz);
    if ($urandom_range(99) < 3) begin
      pz = SKIP_Z;
      sz = -1;
    end
    now_t = $urandom();
    sel   = $urandom_range(99);
    if (sel < 75)      rel_t = now_t - 32'($urandom_range(0, 1 << 20));
    else if (sel < 85) rel_t = now_t;
    else if (sel < 95) rel_t = now_t + 32'($urandom_range(1, 1 << 20));
    else               rel_t = $urandom();
    addr = $urandom();
    // reads lean towards boxes that were recently aimed at
    if (mode == MODE_READ && recent_boxes.size() != 0 && $urandom_range(99) < 60)
      addr = recent_boxes[$urandom_range(recent_boxes.size() - 1)];
    if (mode == MODE_ACCUM && sx >= 0 && sy >= 0 && sz >= 0) begin
      recent_boxes.push_back(ADDR_W'(sz * BOXES_Y_DEF * BOXES_X_DEF + sy * BOXES_X_DEF + sx));
      if (recent_boxes.size() > 16) void'(recent_boxes.pop_front());
    end
    send(mode, px, py, pz, rel_t, now_t, addr, $urandom_range(99) < 10);
  endtask

  initial begin
    logic [DATA_W-1:0] lo [3];
    logic [DATA_W-1:0] iv [3];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) wait_idle();
      gaps_on <= (p % 3 != 2);
      case (p)
        0: load_grid('0, '0, '0, ONE_Q16, ONE_Q16, ONE_Q16, 1'b0);
        1: load_grid(MINUS_EIGHT, MINUS_EIGHT, MINUS_EIGHT, ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
        // zero reciprocal: everything in region lands in slot 0
        2: load_grid(POS_MIN, POS_MIN, POS_MIN, '0, '0, '0, 1'b0);
        3: load_grid(POS_MAX, POS_MAX, POS_MAX, '1, '1, '1, 1'b1);
        // the whole signed range spread over sixteen slots
        4: load_grid(POS_MIN, POS_MIN, POS_MIN, 32'd16, 32'd16, 32'd16, 1'b0);
        default: begin
          for (int a = 0; a < 3; a++) begin
            lo[a] = ($urandom_range(99) < 80) ?
                    32'($urandom_range(0, 2000 << 16)) - 32'(1000 << 16) : $urandom();
            iv[a] = ($urandom_range(99) < 80) ? 32'($urandom_range(1 << 12, 1 << 20))
                                              : $urandom();
          end
          load_grid(lo[0], lo[1], lo[2], iv[0], iv[1], iv[2], 1'b1);
        end
      endcase

      if (p == 0) begin
        // unit boxes from the origin
        send(MODE_READ,  '0, '0, '0, '0, '0, '0, 1'b0);
        send(MODE_ACCUM, '0, '0, '0, '0, '0, '1, 1'b0);
        send(MODE_ACCUM, '0, '0, '0, '0, '0, '0, 1'b1);
        send(MODE_READ,  '1, '1, '1, '1, '1, '0, 1'b0);
        send(MODE_ACCUM, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, '0, '0, '0, 1'b0);
        send(MODE_READ,  '0, '0, '0, '0, '0, '1, 1'b1);
        // past the grid on x and z, below the bound on x and y
        send(MODE_ACCUM, 32'h0010_0000, '0, '0, '0, '0, '0, 1'b0);
        send(MODE_ACCUM, '0, '1, '0, '0, '0, '0, 1'b0);
        send(MODE_ACCUM, '0, '0, POS_MAX, '0, '0, '0, 1'b0);
        send(MODE_ACCUM, POS_MIN, '0, '0, '0, '0, '0, 1'b0);
        // release time after now, and the two time extremes in each order
        send(MODE_ACCUM, ONE_Q16, 32'h0002_0000, 32'h0003_0000, 32'h0000_0001, '0, '0, 1'b0);
        send(MODE_ACCUM, ONE_Q16, 32'h0002_0000, 32'h0003_0000, POS_MAX, POS_MIN, '0, 1'b0);
        send(MODE_ACCUM, ONE_Q16, 32'h0002_0000, 32'h0003_0000, POS_MIN, POS_MAX, '0, 1'b1);
        send(MODE_READ,  '0, '0, '0, '0, '0, 12'h321, 1'b0);
        send(MODE_READ,  '0, '0, '0, '0, '0, 12'h800, 1'b0);
      end else if (p == 1) begin
        // skip marker against its neighbours, all inside the region
        send(MODE_ACCUM, '0, '0, SKIP_Z, '0, ONE_Q16, '0, 1'b0);
        send(MODE_ACCUM, '0, '0, 32'hFFFF_0001, '0, ONE_Q16, '0, 1'b0);
        send(MODE_ACCUM, '0, '0, 32'hFFFE_FFFF, '0, ONE_Q16, '0, 1'b0);
        send(MODE_ACCUM, '0, '0, SKIP_Z, '0, ONE_Q16, '0, 1'b1);
        send(MODE_READ,  '0, '0, '0, '0, '0, 12'h788, 1'b0);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_request();
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
